>>> rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the stream find-and-replace block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    // field and register widths, queue depth
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 5;
    localparam int REG_BYTES   = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 6;
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes (byte address = 8 * index)
    typedef enum logic [2:0] {
        REG_PLEN   = 3'd0,
        REG_PAT_LO = 3'd1,
        REG_PAT_HI = 3'd2,
        REG_RLEN   = 3'd3,
        REG_REP_LO = 3'd4,
        REG_REP_HI = 3'd5
    } reg_idx_t;

    // configuration as seen by the datapath, lengths already clamped
    typedef struct packed {
        logic [REG_BYTES-1:0][BYTE_W-1:0] pat;
        logic [REG_BYTES-1:0][BYTE_W-1:0] rep;
        logic [LEN_W-1:0]                 plen;
        logic [LEN_W-1:0]                 rlen;
    } sfr_cfg_t;

    // command kinds passed from the front to the back
    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_REPL = 2'd1,
        CMD_MARK = 2'd2
    } cmd_kind_t;

    // one queued command
    typedef struct packed {
        cmd_kind_t         kind;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              eos;
    } sfr_cmd_t;

    // front state machine
    typedef enum logic {
        FR_IDLE = 1'b0,
        FR_SCAN = 1'b1
    } front_state_t;

endpackage

`default_nettype wire

>>> rtl/sfr_regs.sv
// ----------------------------------------------------------------------------
// sfr_regs
// APB register file holding pattern and replacement, lengths clamped for use.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_regs #(
    parameter int PAT_LIM = 16,
    parameter int REP_LIM = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sfr_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [sfr_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output sfr_pkg::sfr_cfg_t                cfg
);
    import sfr_pkg::*;

    localparam logic [LEN_W-1:0] PLIM = LEN_W'(PAT_LIM < REG_BYTES ? PAT_LIM : REG_BYTES);
    localparam logic [LEN_W-1:0] RLIM = LEN_W'(REP_LIM < REG_BYTES ? REP_LIM : REG_BYTES);

    logic [LEN_W-1:0]      plen_reg;
    logic [LEN_W-1:0]      rlen_reg;
    logic [CFG_DATA_W-1:0] pat_lo_reg;
    logic [CFG_DATA_W-1:0] pat_hi_reg;
    logic [CFG_DATA_W-1:0] rep_lo_reg;
    logic [CFG_DATA_W-1:0] rep_hi_reg;
    logic                  wr_en;
    reg_idx_t              reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg   <= '0;
            rlen_reg   <= '0;
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            rep_lo_reg <= '0;
            rep_hi_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_PLEN:   plen_reg   <= pwdata[LEN_W-1:0];
                REG_PAT_LO: pat_lo_reg <= pwdata;
                REG_PAT_HI: pat_hi_reg <= pwdata;
                REG_RLEN:   rlen_reg   <= pwdata[LEN_W-1:0];
                REG_REP_LO: rep_lo_reg <= pwdata;
                REG_REP_HI: rep_hi_reg <= pwdata;
                default:    ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_sel)
            REG_PLEN:   prdata = CFG_DATA_W'(plen_reg);
            REG_PAT_LO: prdata = pat_lo_reg;
            REG_PAT_HI: prdata = pat_hi_reg;
            REG_RLEN:   prdata = CFG_DATA_W'(rlen_reg);
            REG_REP_LO: prdata = rep_lo_reg;
            REG_REP_HI: prdata = rep_hi_reg;
            default:    prdata = '0;
        endcase
    end

    // datapath view, lengths limited to what the window and registers hold
    assign cfg.pat  = {pat_hi_reg, pat_lo_reg};
    assign cfg.rep  = {rep_hi_reg, rep_lo_reg};
    assign cfg.plen = (plen_reg > PLIM) ? PLIM : plen_reg;
    assign cfg.rlen = (rlen_reg > RLIM) ? RLIM : rlen_reg;

endmodule

`default_nettype wire

>>> rtl/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front
// Accepts input bytes, keeps the match window and turns each byte into
// commands for the back: released bytes, a replacement run or an end marker.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_front #(
    parameter int WIN = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sfr_pkg::BYTE_W-1:0]    s_tdata,
    input  logic                          s_tlast,
    input  sfr_pkg::sfr_cfg_t             cfg,
    output logic                          push,
    output sfr_pkg::sfr_cmd_t             push_cmd,
    input  logic                          q_full
);
    import sfr_pkg::*;

    localparam int IW = (WIN > 1) ? $clog2(WIN) : 1;

    function automatic sfr_cmd_t make_cmd(cmd_kind_t k, logic [BYTE_W-1:0] d,
                                          logic l, logic e);
        sfr_cmd_t c;
        c.kind = k;
        c.data = d;
        c.last = l;
        c.eos  = e;
        return c;
    endfunction

    logic [BYTE_W-1:0] win_reg [WIN];
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    front_state_t      state_reg, state_next;
    logic              eos_reg, eos_next;
    logic              first_reg, first_next;
    logic              held_vld_reg, held_vld_next;
    sfr_cmd_t          held_reg, held_next;

    logic              pfx;
    logic              is_match;
    logic              must_rel;
    logic              want;
    logic              do_accept;
    logic              do_shift;
    sfr_cmd_t          fin_cmd;

    // window is a prefix of the pattern over its pending bytes
    always_comb
    begin
        pfx = 1'b1;
        for (int i = 0; i < WIN; i++)
        begin
            if ((LEN_W'(i) < cnt_reg) && (win_reg[i] != cfg.pat[i]))
                pfx = 1'b0;
        end
    end

    assign is_match = first_reg && (cnt_reg == cfg.plen) && pfx;
    assign must_rel = (cnt_reg != '0) && (eos_reg || !((cnt_reg < cfg.plen) && pfx));

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FR_IDLE;
            cnt_reg      <= '0;
            eos_reg      <= 1'b0;
            first_reg    <= 1'b0;
            held_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            eos_reg      <= eos_next;
            first_reg    <= first_next;
            held_vld_reg <= held_vld_next;
        end
    end

    // held command and window bytes
    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        if (do_accept)
            win_reg[cnt_reg[IW-1:0]] <= s_tdata;
        else if (do_shift)
        begin
            for (int i = 0; i < WIN - 1; i++)
                win_reg[i] <= win_reg[i + 1];
        end
    end

    // next state and command generation
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        eos_next      = eos_reg;
        first_next    = first_reg;
        held_vld_next = held_vld_reg;
        held_next     = held_reg;
        push          = 1'b0;
        push_cmd      = held_reg;
        s_tready      = 1'b0;
        do_accept     = 1'b0;
        do_shift      = 1'b0;
        want          = 1'b0;
        fin_cmd       = make_cmd(CMD_MARK, '0, 1'b1, eos_reg);

        unique case (state_reg)
            FR_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    do_accept  = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    eos_next   = s_tlast;
                    first_next = 1'b1;
                    state_next = FR_SCAN;
                end
            end
            FR_SCAN:
            begin
                if (is_match)
                begin
                    // whole pattern seen: a replacement run unless rlen is zero, window empties
                    if (cfg.rlen != '0)
                    begin
                        fin_cmd = make_cmd(CMD_REPL, '0, 1'b1, eos_reg);
                        want    = 1'b1;
                    end
                    else if (eos_reg)
                        want = 1'b1;
                    if (!want || !q_full)
                    begin
                        push       = want;
                        push_cmd   = fin_cmd;
                        cnt_next   = '0;
                        first_next = 1'b0;
                        state_next = FR_IDLE;
                    end
                end
                else if (must_rel)
                begin
                    // release the front byte, the one before it goes out
                    if (!held_vld_reg || !q_full)
                    begin
                        push          = held_vld_reg;
                        push_cmd      = held_reg;
                        held_next     = make_cmd(CMD_BYTE, win_reg[0], 1'b0, 1'b0);
                        held_vld_next = 1'b1;
                        do_shift      = 1'b1;
                        cnt_next      = cnt_reg - 1'b1;
                        first_next    = 1'b0;
                    end
                end
                else
                begin
                    // run complete: mark its final command
                    if (held_vld_reg)
                    begin
                        fin_cmd = make_cmd(held_reg.kind, held_reg.data, 1'b1, eos_reg);
                        want    = 1'b1;
                    end
                    else if (eos_reg)
                        want = 1'b1;
                    if (!want || !q_full)
                    begin
                        push          = want;
                        push_cmd      = fin_cmd;
                        held_vld_next = 1'b0;
                        first_next    = 1'b0;
                        state_next    = FR_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/sfr_queue.sv
// ----------------------------------------------------------------------------
// sfr_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sfr_pkg::sfr_cmd_t    push_cmd,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_vld,
    output sfr_pkg::sfr_cmd_t    head
);
    import sfr_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    sfr_cmd_t       mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW:0]    fill_reg;
    logic           do_push;
    logic           do_pop;

    assign full     = (fill_reg == (PW + 1)'(QUEUE_DEPTH));
    assign head_vld = (fill_reg != '0);
    assign head     = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && head_vld;

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

>>> rtl/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back
// Expands queued commands into result requests and holds them in the
// output register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_vld,
    input  sfr_pkg::sfr_cmd_t             q_head,
    output logic                          pop,
    input  sfr_pkg::sfr_cfg_t             cfg,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sfr_pkg::BYTE_W-1:0]    m_tdata,
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast
);
    import sfr_pkg::*;

    logic              cur_vld_reg;
    sfr_cmd_t          cur_reg;
    logic [LEN_W-2:0]  ridx_reg;
    logic              m_vld_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [1:0]        user_reg;
    logic              eos_reg;

    logic              slot_free;
    logic              run_end;
    logic              emit;
    logic [BYTE_W-1:0] res_data;
    logic              res_bvalid;
    logic              res_last;

    assign slot_free = !m_vld_reg || m_tready;
    assign run_end   = (cur_reg.kind != CMD_REPL) ||
                       ({1'b0, ridx_reg} == (cfg.rlen - 1'b1));
    assign emit      = cur_vld_reg && slot_free;
    assign pop       = q_vld && (!cur_vld_reg || (emit && run_end));
    assign res_last  = cur_reg.last && run_end;

    // result byte for the current command
    always_comb
    begin
        unique case (cur_reg.kind)
            CMD_BYTE:
            begin
                res_data   = cur_reg.data;
                res_bvalid = 1'b1;
            end
            CMD_REPL:
            begin
                res_data   = cfg.rep[ridx_reg];
                res_bvalid = 1'b1;
            end
            default:
            begin
                res_data   = '0;
                res_bvalid = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_vld_reg <= 1'b0;
            m_vld_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
                cur_vld_reg <= 1'b1;
            else if (emit && run_end)
                cur_vld_reg <= 1'b0;
            if (emit)
                m_vld_reg <= 1'b1;
            else if (m_tready)
                m_vld_reg <= 1'b0;
        end
    end

    // command and output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg  <= q_head;
            ridx_reg <= '0;
        end
        else if (emit && !run_end)
            ridx_reg <= ridx_reg + 1'b1;
        if (emit)
        begin
            data_reg <= res_data;
            user_reg <= {res_last, res_bvalid};
            eos_reg  <= res_last && cur_reg.eos;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = eos_reg;

endmodule

`default_nettype wire

>>> rtl/stream_find_replace.sv
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming find-and-replace of a configured byte pattern in a byte stream.
// ----------------------------------------------------------------------------
//   channel   | direction | payload
//   s_axis    | in        | tdata = in_byte, tlast = end_of_input
//   m_axis    | out       | tdata = out_byte, tuser = {last_of_run, byte_valid},
//             |           | tlast = end_of_output
//   apb       | in/out    | six registers at byte address 8*i, 64-bit data
//
// An input byte is accepted by the front and then scanned; each window byte that it releases
// goes through the release loop, which moves one byte per cycle while the queue has room.
// The back issues one result per cycle while the output is not stalled; a replacement run of
// r bytes holds it until all r are issued, and a four-entry command queue lets the front run
// ahead. Reset empties the window and clears the control and configuration registers; no
// clearing pass. A stalled output only stops the front once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_find_replace #(
    parameter int MAX_PATTERN = 16,
    parameter int MAX_REPLACE = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sfr_pkg::BYTE_W-1:0]      s_axis_tdata,   // [7:0] in_byte
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sfr_pkg::BYTE_W-1:0]      m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]                      m_axis_tuser,   // [0] byte_valid, [1] last_of_run
    output logic                            m_axis_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sfr_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [sfr_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import sfr_pkg::*;

    localparam int WIN = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;

    sfr_cfg_t cfg;
    logic     push;
    sfr_cmd_t push_cmd;
    logic     q_full;
    logic     pop;
    logic     q_vld;
    sfr_cmd_t q_head;

    // configuration registers
    sfr_regs #(
        .PAT_LIM (MAX_PATTERN),
        .REP_LIM (MAX_REPLACE)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // window and match decisions
    sfr_front #(
        .WIN (WIN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tlast  (s_axis_tlast),
        .cfg      (cfg),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    // command queue
    sfr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head_vld (q_vld),
        .head     (q_head)
    );

    // result expansion and output register
    sfr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_vld    (q_vld),
        .q_head   (q_head),
        .pop      (pop),
        .cfg      (cfg),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .m_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks of the find-and-replace block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [sfr_pkg::BYTE_W-1:0]      m_axis_tdata,
    input logic [1:0]                      m_axis_tuser,
    input logic                            m_axis_tlast
);

    // a stalled result request holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // end of stream only on the last result of a run
    a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
        else $error("end of output without last of run");

    // the empty marker only closes a stream and carries a zero byte
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tlast && m_axis_tuser[1] && (m_axis_tdata == '0))
        else $error("empty marker outside stream end");

    // one input at a time: the front scans before taking another
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stream find-and-replace block. A behavioral
// predictor tracks the match window and register settings, builds the
// expected output bytes for every accepted request and a monitor compares
// them with the master stream. Directed cases come first, then phases of
// random streams built from pattern copies, partial prefixes and noise.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RUN_MAX      = 16;
    localparam int WIN_SIZE     = 16;

    // one expected output request
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic       eos;
    } out_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;    // [7:0] in_byte
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [BYTE_W-1:0]     m_axis_tdata;    // [7:0] out_byte
    logic [1:0]            m_axis_tuser;    // [0] byte_valid, [1] last_of_run
    logic                  m_axis_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor copy of the registers and the match window
    logic [4:0]  cfg_plen   = '0;
    logic [63:0] cfg_pat_lo = '0;
    logic [63:0] cfg_pat_hi = '0;
    logic [4:0]  cfg_rlen   = '0;
    logic [63:0] cfg_rep_lo = '0;
    logic [63:0] cfg_rep_hi = '0;
    logic [7:0]  win [WIN_SIZE];
    int          win_cnt = 0;

    out_item_t   run_q[$];
    out_item_t   rewritten_q[$];

    bit          gaps_on = 1'b1;
    int          errors = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          settings_used = 0;
    int          idle_cycles = 0;
    out_item_t   got;
    out_item_t   want;

    stream_find_replace DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // byte i of a lo/hi register pair
    function automatic logic [7:0] reg_byte(logic [63:0] lo, logic [63:0] hi, int idx);
        if (idx < 8)
            return lo[8*idx +: 8];
        return hi[8*(idx-8) +: 8];
    endfunction

    function automatic int clamp_len(logic [4:0] v);
        return (v > WIN_SIZE) ? WIN_SIZE : int'(v);
    endfunction

    // window holds the first cnt bytes of the pattern
    function automatic bit window_matches(int cnt);
        int i;
        for (i = 0; i < cnt; i++)
            if (win[i] != reg_byte(cfg_pat_lo, cfg_pat_hi, i))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void push_result(logic [7:0] d, logic v);
        out_item_t r;
        if (run_q.size() >= RUN_MAX)
            return;
        r.data  = d;
        r.valid = v;
        r.last  = 1'b0;
        r.eos   = 1'b0;
        run_q.push_back(r);
    endfunction

    // release the oldest pending byte
    function automatic void shift_out_head();
        int i;
        push_result(win[0], 1'b1);
        for (i = 0; i < WIN_SIZE - 1; i++)
            win[i] = win[i+1];
        win[WIN_SIZE-1] = 8'h00;
        win_cnt--;
    endfunction

    // expected output run for one input byte
    function automatic void rewrite_byte(logic [7:0] b, logic eoi);
        int        plen;
        int        rlen;
        int        i;
        out_item_t r;
        plen = clamp_len(cfg_plen);
        rlen = clamp_len(cfg_rlen);
        run_q.delete();
        if (win_cnt >= WIN_SIZE)
            shift_out_head();
        win[win_cnt] = b;
        win_cnt++;
        if (win_cnt == plen && window_matches(win_cnt))
        begin
            for (i = 0; i < rlen; i++)
                push_result(reg_byte(cfg_rep_lo, cfg_rep_hi, i), 1'b1);
            win_cnt = 0;
        end
        else
        begin
            while (win_cnt > 0 && !(win_cnt < plen && window_matches(win_cnt)))
                shift_out_head();
        end
        if (eoi)
        begin
            while (win_cnt > 0)
                shift_out_head();
            if (run_q.size() == 0)
                push_result(8'h00, 1'b0);
        end
        if (run_q.size() > 0)
        begin
            r = run_q.pop_back();
            r.last = 1'b1;
            r.eos  = eoi;
            run_q.push_back(r);
        end
        for (i = 0; i < run_q.size(); i++)
            rewritten_q.push_back(run_q[i]);
    endfunction

    // one register write: setup then access
    task automatic cfg_write(reg_idx_t idx, logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 3'b000});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PLEN:   cfg_plen   = val[4:0];
            REG_PAT_LO: cfg_pat_lo = val;
            REG_PAT_HI: cfg_pat_hi = val;
            REG_RLEN:   cfg_rlen   = val[4:0];
            REG_REP_LO: cfg_rep_lo = val;
            REG_REP_HI: cfg_rep_hi = val;
            default:    ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_config(logic [4:0] plen, logic [63:0] plo, logic [63:0] phi,
                               logic [4:0] rlen, logic [63:0] rlo, logic [63:0] rhi);
        cfg_write(REG_PLEN, 64'(plen));
        cfg_write(REG_PAT_LO, plo);
        cfg_write(REG_PAT_HI, phi);
        cfg_write(REG_RLEN, 64'(rlen));
        cfg_write(REG_REP_LO, rlo);
        cfg_write(REG_REP_HI, rhi);
        settings_used++;
    endtask

    // one input request, with an optional idle burst ahead of it
    task automatic send_item(logic [7:0] b, logic eoi);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eoi;
        do @(posedge clk); while (!s_axis_tready);
        rewrite_byte(b, eoi);
        items_sent++;
    endtask

    // block is idle once all results are in and the front has settled
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (rewritten_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // reset values act as pass-through
    task automatic test_passthrough_after_reset();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h5A, 1'b1);
        wait_for_results();
    endtask

    // "ab" -> "XYZ", leading byte released, trailing prefix flushed
    task automatic test_single_match();
        load_config(5'd2, 64'h6261, 64'h0, 5'd3, 64'h5A5958, 64'h0);
        send_item(8'h61, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b0);
        send_item(8'h61, 1'b1);
        wait_for_results();
    endtask

    // "aab" in "aaab": leftmost match, completed on the final byte
    task automatic test_leftmost_overlap();
        load_config(5'd3, 64'h626161, 64'h0, 5'd1, 64'h23, 64'h0);
        send_item(8'h61, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b1);
        wait_for_results();
    endtask

    // empty replacement deletes, a final deleted byte gives the end marker
    task automatic test_delete_match();
        load_config(5'd1, 64'h71, 64'h0, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        send_item(8'h71, 1'b0);
        send_item(8'h78, 1'b0);
        send_item(8'h71, 1'b1);
        wait_for_results();
    endtask

    // pending window checked against a shorter pattern after a rewrite
    task automatic test_config_mid_stream();
        load_config(5'd4, 64'h64636261, 64'h0, 5'd2, 64'h2B2A, 64'h0);
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b0);
        send_item(8'h63, 1'b0);
        wait_for_results();
        cfg_write(REG_PLEN, 64'd2);
        send_item(8'h64, 1'b1);
        wait_for_results();
    endtask

    // random streams under one register setting
    task automatic run_phase(int n_items, int plen, int rlen, bit narrow);
        logic [7:0]  alpha [3];
        logic [7:0]  text[$];
        logic [63:0] plo;
        logic [63:0] phi;
        int          i;
        int          k;
        int          m;
        int          eff;
        int          sent;
        int          target;
        for (i = 0; i < 3; i++)
            alpha[i] = 8'($urandom_range(0, 255));
        for (i = 0; i < 8; i++)
        begin
            plo[8*i +: 8] = narrow ? alpha[$urandom_range(0, 2)] : 8'($urandom_range(0, 255));
            phi[8*i +: 8] = narrow ? alpha[$urandom_range(0, 2)] : 8'($urandom_range(0, 255));
        end
        wait_for_results();
        load_config(5'(plen), plo, phi, 5'(rlen),
                    {$urandom, $urandom}, {$urandom, $urandom});
        eff  = (plen > WIN_SIZE) ? WIN_SIZE : plen;
        sent = 0;
        while (sent < n_items)
        begin
            text.delete();
            target = $urandom_range(1, (eff > 8) ? 40 : 20);
            // pattern copies, broken prefixes and noise
            while (text.size() < target)
            begin
                k = $urandom_range(0, 7);
                if (k < 3 && eff > 0)
                begin
                    for (i = 0; i < eff; i++)
                        text.push_back(reg_byte(plo, phi, i));
                end
                else if (k < 5 && eff > 1)
                begin
                    m = $urandom_range(1, eff - 1);
                    for (i = 0; i < m; i++)
                        text.push_back(reg_byte(plo, phi, i));
                    text.push_back(alpha[$urandom_range(0, 2)]);
                end
                else if (k < 7)
                    text.push_back(alpha[$urandom_range(0, 2)]);
                else
                    text.push_back(8'($urandom_range(0, 255)));
            end
            // keep the phase within its byte budget
            while (text.size() > n_items - sent)
                void'(text.pop_back());
            for (i = 0; i < text.size(); i++)
            begin
                send_item(text[i], i == text.size() - 1);
                sent++;
            end
        end
    endtask

    task automatic test_random_single();
        run_phase(50, 1, 1, 1'b1);
    endtask

    task automatic test_random_short();
        run_phase(60, $urandom_range(2, 5), $urandom_range(0, 5), 1'b1);
    endtask

    // lengths above the register capacity clamp to 16
    task automatic test_random_clamped();
        run_phase(70, 31, 31, 1'b1);
    endtask

    task automatic test_random_passthrough();
        gaps_on = 1'b0;
        run_phase(40, 0, $urandom_range(0, 16), 1'b0);
        gaps_on = 1'b1;
    endtask

    task automatic test_random_delete();
        run_phase(50, 16, 0, 1'b1);
    endtask

    task automatic test_random_mixed();
        int r;
        for (r = 0; r < 3; r++)
            run_phase(30, $urandom_range(1, 20), $urandom_range(0, 20), (r % 2) == 0);
    endtask

    task automatic test_random_final();
        gaps_on = 1'b0;
        run_phase(50, 3, 2, 1'b1);
    endtask

    // stimulus and end of run
    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough_after_reset();
        test_single_match();
        test_leftmost_overlap();
        test_delete_match();
        test_config_mid_stream();
        test_random_single();
        test_random_short();
        test_random_clamped();
        test_random_passthrough();
        test_random_delete();
        test_random_mixed();
        test_random_final();
        wait_for_results();

        $display("covered %0d input bytes, %0d output results, %0d register settings",
                 items_sent, results_seen, settings_used);
        $display("incl. pass-through, overlap, deletion, flush, mid-stream change, clamping");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // output back-pressure in random bursts
    initial
    begin
        m_axis_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // compare each output request with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.data  = m_axis_tdata;
            got.valid = m_axis_tuser[0];
            got.last  = m_axis_tuser[1];
            got.eos   = m_axis_tlast;
            results_seen++;
            if (rewritten_q.size() == 0)
            begin
                $display("%0t: unexpected result data=%02h valid=%b last=%b eos=%b",
                         $realtime, got.data, got.valid, got.last, got.eos);
                errors++;
            end
            else
            begin
                want = rewritten_q.pop_front();
                if (got.data !== want.data || got.valid !== want.valid ||
                    got.last !== want.last || got.eos !== want.eos)
                begin
                    $display("%0t: mismatch expected data=%02h valid=%b last=%b eos=%b, %s",
                             $realtime, want.data, want.valid, want.last, want.eos,
                             $sformatf("actual data=%02h valid=%b last=%b eos=%b",
                                       got.data, got.valid, got.last, got.eos));
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
